### rtl/core/first_fit_heap_allocator_top_assert.svh
// Assertion macros shared by the allocator's checker.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFHA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ffha_pkg.sv
// Shared types, codes and defaults of the first-fit heap allocator.
// No dependencies; imported by ffha_align, ffha_ctrl, ffha_datapath, the top level and the checker.
package ffha_pkg;

    localparam int DEF_FREE_ENTRIES = 64;
    localparam int DEF_BUSY_ENTRIES = 64;
    localparam int DEF_HUNK_ENTRIES = 32;
    localparam int DEF_ALIGN_BYTES  = 8;
    localparam int DEF_ADDR_BITS    = 32;

    localparam logic [31:0] DEFAULT_HUNK  = 32'd65536;
    localparam logic [31:0] DEFAULT_LIMIT = 32'hFFFF_FFFF;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LIMIT    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOT_BUSY = 2'd3;

    // Item kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_HUNK_SIZE  = 1'b0;
    localparam logic CFG_HEAP_LIMIT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] request_bytes;
        logic [31:0] block_address;
    } item_in_t;

    typedef struct packed {
        logic [31:0] granted_address;
        logic [31:0] granted_bytes;
        logic [1:0]  status;
    } item_out_t;

    typedef enum logic [1:0] {
        SCAN_FREE,
        SCAN_BUSY,
        SCAN_HUNK
    } scan_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      align_go;
        logic      align_hunk;
        logic      take_hunk;
        logic      take_n;
        logic      scan_go;
        scan_sel_t scan_sel;
        logic      commit;
    } ffha_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic align_done;
        logic scan_done;
        logic busy_hit;
    } ffha_sts_t;

endpackage

### rtl/core/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ffha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/ffha_align.sv
// Round-up unit: value rounded up to a multiple of ALIGN_BYTES by reciprocal
// multiplication. Depends on ffha_pkg for the default alignment.
module ffha_align import ffha_pkg::*; #(
    parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [31:0] value,
    output logic        done,
    output logic [32:0] result
);

    localparam int DW  = 33;
    localparam int LW  = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 0;
    localparam int K   = DW + LW;
    localparam int MW  = DW + 2;
    localparam int MLW = 18;
    localparam int MHW = MW - MLW;
    localparam int PW  = DW + MW;
    localparam logic [63:0] MAGIC64 =
        ((64'd1 << K) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
    localparam logic [MLW-1:0] MAGIC_LO = MLW'(MAGIC64);
    localparam logic [MHW-1:0] MAGIC_HI = MHW'(MAGIC64 >> MLW);
    localparam logic [DW-1:0]  MULT     = DW'(ALIGN_BYTES);
    localparam logic [DW-1:0]  BIAS     = DW'(ALIGN_BYTES - 1);

    logic [DW-1:0]     x_reg;
    logic [DW+MLW-1:0] plo_reg;
    logic [DW+MHW-1:0] phi_reg;
    logic [DW-1:0]     q_reg;
    logic [DW-1:0]     result_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic              done_reg;
    logic [PW-1:0]     prod;

    // Recombine the two partial products of value times the reciprocal.
    always_comb
    begin
        prod = PW'(plo_reg) + (PW'(phi_reg) << MLW);
    end

    // Biased value, partial products, quotient, then the multiply back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            plo_reg    <= '0;
            phi_reg    <= '0;
            q_reg      <= '0;
            result_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            v1_reg   <= go;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
            if (go)
            begin
                x_reg <= {1'b0, value} + BIAS;
            end
            if (v1_reg)
            begin
                plo_reg <= (DW+MLW)'(x_reg) * (DW+MLW)'(MAGIC_LO);
                phi_reg <= (DW+MHW)'(x_reg) * (DW+MHW)'(MAGIC_HI);
            end
            if (v2_reg)
            begin
                q_reg <= DW'(prod >> K);
            end
            if (v3_reg)
            begin
                result_reg <= DW'(q_reg * MULT);
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/core/ffha_ctrl.sv
// Controller of the allocator: sequences alignment, table scans and commit.
// Depends on ffha_pkg for the command and status structs.
module ffha_ctrl import ffha_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      kind,
    input  ffha_sts_t sts,
    output ffha_cmd_t cmd,
    output logic      busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALIGN_HUNK,
        S_ALIGN_REQ,
        S_SCAN_BUSY,
        S_SCAN_HUNK,
        S_SCAN_FREE,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    // Next state and commands.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (kind == KIND_FREE)
                    begin
                        cmd.scan_go  = 1'b1;
                        cmd.scan_sel = SCAN_BUSY;
                        state_next   = S_SCAN_BUSY;
                    end
                    else
                    begin
                        cmd.align_go   = 1'b1;
                        cmd.align_hunk = 1'b1;
                        state_next     = S_ALIGN_HUNK;
                    end
                end
            end
            S_ALIGN_HUNK:
            begin
                if (sts.align_done)
                begin
                    cmd.take_hunk = 1'b1;
                    cmd.align_go  = 1'b1;
                    state_next    = S_ALIGN_REQ;
                end
            end
            S_ALIGN_REQ:
            begin
                if (sts.align_done)
                begin
                    cmd.take_n   = 1'b1;
                    cmd.scan_go  = 1'b1;
                    cmd.scan_sel = SCAN_FREE;
                    state_next   = S_SCAN_FREE;
                end
            end
            S_SCAN_BUSY:
            begin
                if (sts.scan_done)
                begin
                    if (sts.busy_hit)
                    begin
                        cmd.scan_go  = 1'b1;
                        cmd.scan_sel = SCAN_HUNK;
                        state_next   = S_SCAN_HUNK;
                    end
                    else
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_SCAN_HUNK:
            begin
                if (sts.scan_done)
                begin
                    cmd.scan_go  = 1'b1;
                    cmd.scan_sel = SCAN_FREE;
                    state_next   = S_SCAN_FREE;
                end
            end
            S_SCAN_FREE:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and the registered busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

### rtl/core/ffha_datapath.sv
// Datapath of the allocator: tables in RAM, valid bits, scan logic and commit.
// Depends on ffha_pkg, ffha_ram and ffha_align.
module ffha_datapath import ffha_pkg::*; #(
    parameter int FREE_ENTRIES = DEF_FREE_ENTRIES,
    parameter int BUSY_ENTRIES = DEF_BUSY_ENTRIES,
    parameter int HUNK_ENTRIES = DEF_HUNK_ENTRIES,
    parameter int ALIGN_BYTES  = DEF_ALIGN_BYTES,
    parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  ffha_cmd_t   cmd,
    output ffha_sts_t   sts,
    input  item_in_t    item,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output item_out_t   result,
    output logic        done
);

    localparam int FAW  = $clog2(FREE_ENTRIES);
    localparam int BAW  = $clog2(BUSY_ENTRIES);
    localparam int HAW  = HUNK_ENTRIES > 1 ? $clog2(HUNK_ENTRIES) : 1;
    localparam int HCW  = $clog2(HUNK_ENTRIES + 1);
    localparam int MAXD = FREE_ENTRIES > BUSY_ENTRIES ?
                          (FREE_ENTRIES > HUNK_ENTRIES ? FREE_ENTRIES : HUNK_ENTRIES) :
                          (BUSY_ENTRIES > HUNK_ENTRIES ? BUSY_ENTRIES : HUNK_ENTRIES);
    localparam int CW   = $clog2(MAXD + 1);
    localparam logic [31:0] HCAP = 32'((64'hFFFF_FFFF / ALIGN_BYTES) * ALIGN_BYTES);
    localparam logic [33:0] CAP  = (ADDR_BITS < 32) ? (34'd1 << ADDR_BITS) : 34'h1_0000_0000;

    // Configuration and item registers.
    logic [31:0] hunk_raw_reg;
    logic [31:0] limit_reg;
    logic        kind_reg;
    logic [31:0] req_reg;
    logic [31:0] addr_reg;
    logic [31:0] hunk_reg;
    logic [32:0] n_reg;

    // Allocator state.
    logic [FREE_ENTRIES-1:0] free_valid_reg;
    logic [BUSY_ENTRIES-1:0] busy_valid_reg;
    logic [HCW-1:0]          hunk_count_reg;
    logic [32:0]             used_reg;

    // Scan engine.
    scan_sel_t   sel_reg;
    logic        active_reg;
    logic [CW-1:0] cnt_reg;
    logic        pend_reg;
    logic [CW-1:0] pidx_reg;
    logic [CW-1:0] lim;
    logic        issue;
    logic        scan_done;

    // Scan findings.
    logic           fit_reg;
    logic [FAW-1:0] fit_idx_reg;
    logic [31:0]    fit_start_reg;
    logic [31:0]    fit_len_reg;
    logic           bhit_reg;
    logic [BAW-1:0] bidx_reg;
    logic [31:0]    blen_reg;
    logic           base_a_reg;
    logic           base_e_reg;
    logic           lo_reg;
    logic [FAW-1:0] lo_idx_reg;
    logic [31:0]    lo_start_reg;
    logic [31:0]    lo_len_reg;
    logic           hi_reg;
    logic [FAW-1:0] hi_idx_reg;
    logic [31:0]    hi_len_reg;

    // Result register.
    item_out_t result_reg;
    logic      done_reg;

    // RAM ports.
    logic           fr_we;
    logic [FAW-1:0] fr_waddr;
    logic [63:0]    fr_wdata;
    logic [63:0]    fr_rdata;
    logic           br_we;
    logic [BAW-1:0] br_waddr;
    logic [63:0]    br_wdata;
    logic [63:0]    br_rdata;
    logic           hr_we;
    logic [31:0]    hr_rdata;

    // Alignment unit.
    logic        al_done;
    logic [32:0] al_result;
    logic [31:0] al_value;

    // Evaluation of the entry read out.
    logic [31:0]    rd_start;
    logic [31:0]    rd_len;
    logic           rd_fvld;
    logic           rd_bvld;
    logic [FAW-1:0] pidx_f;
    logic [32:0]    end_addr;
    logic           fit_hit;
    logic           lo_hit;
    logic           hi_hit;
    logic           b_hit;

    // Commit decision.
    logic           fe_found;
    logic [FAW-1:0] fe_idx;
    logic           be_found;
    logic [BAW-1:0] be_idx;
    logic [32:0]    grow;
    logic           below_hunk;
    logic [33:0]    limit_eff;
    logic [33:0]    sum;
    logic [1:0]     st;
    logic [31:0]    out_addr;
    logic [31:0]    out_bytes;
    logic           fv_set;
    logic [FAW-1:0] fv_set_idx;
    logic           fv_clr;
    logic [FAW-1:0] fv_clr_idx;
    logic           bv_set;
    logic           bv_clr;
    logic           grow_ok;
    logic [31:0]    tot;

    ffha_align #(.ALIGN_BYTES(ALIGN_BYTES)) u_align (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (cmd.align_go),
        .value  (al_value),
        .done   (al_done),
        .result (al_result)
    );

    ffha_ram #(.WIDTH(64), .DEPTH(FREE_ENTRIES)) u_free_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (cnt_reg[FAW-1:0]),
        .rdata (fr_rdata)
    );

    ffha_ram #(.WIDTH(64), .DEPTH(BUSY_ENTRIES)) u_busy_ram (
        .clk   (clk),
        .we    (br_we),
        .waddr (br_waddr),
        .wdata (br_wdata),
        .raddr (cnt_reg[BAW-1:0]),
        .rdata (br_rdata)
    );

    ffha_ram #(.WIDTH(32), .DEPTH(HUNK_ENTRIES)) u_hunk_ram (
        .clk   (clk),
        .we    (hr_we),
        .waddr (hunk_count_reg[HAW-1:0]),
        .wdata (used_reg[31:0]),
        .raddr (cnt_reg[HAW-1:0]),
        .rdata (hr_rdata)
    );

    // Value to align: the hunk size (zero means the default) or the request.
    always_comb
    begin
        if (cmd.align_hunk)
        begin
            al_value = (hunk_raw_reg == 32'd0) ? DEFAULT_HUNK : hunk_raw_reg;
        end
        else
        begin
            al_value = (req_reg == 32'd0) ? 32'd1 : req_reg;
        end
    end

    // Scan bounds and handshake with the controller.
    always_comb
    begin
        case (sel_reg)
            SCAN_FREE: lim = CW'(FREE_ENTRIES);
            SCAN_BUSY: lim = CW'(BUSY_ENTRIES);
            SCAN_HUNK: lim = CW'(hunk_count_reg);
            default:   lim = '0;
        endcase
        issue     = active_reg && (cnt_reg != lim);
        scan_done = active_reg && (cnt_reg == lim) && !pend_reg;
    end

    assign sts.align_done = al_done;
    assign sts.scan_done  = scan_done;
    assign sts.busy_hit   = bhit_reg;

    // Match logic for the entry that the RAMs return this cycle.
    always_comb
    begin
        pidx_f   = pidx_reg[FAW-1:0];
        rd_start = (sel_reg == SCAN_BUSY) ? br_rdata[63:32] : fr_rdata[63:32];
        rd_len   = (sel_reg == SCAN_BUSY) ? br_rdata[31:0] : fr_rdata[31:0];
        rd_fvld  = free_valid_reg[pidx_f];
        rd_bvld  = busy_valid_reg[pidx_reg[BAW-1:0]];
        end_addr = {1'b0, addr_reg} + {1'b0, blen_reg};
        fit_hit  = pend_reg && (sel_reg == SCAN_FREE) && (kind_reg == KIND_ALLOC) && rd_fvld
                   && ({1'b0, rd_len} >= n_reg) && (!fit_reg || (rd_start < fit_start_reg));
        lo_hit   = pend_reg && (sel_reg == SCAN_FREE) && (kind_reg == KIND_FREE) && rd_fvld
                   && !base_a_reg && (({1'b0, rd_start} + {1'b0, rd_len}) == {1'b0, addr_reg});
        hi_hit   = pend_reg && (sel_reg == SCAN_FREE) && (kind_reg == KIND_FREE) && rd_fvld
                   && !base_e_reg && ({1'b0, rd_start} == end_addr);
        b_hit    = pend_reg && (sel_reg == SCAN_BUSY) && rd_bvld && !bhit_reg
                   && (rd_start == addr_reg);
    end

    // First empty entries of the free and busy tables.
    always_comb
    begin
        fe_found = 1'b0;
        fe_idx   = '0;
        for (int i = FREE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!free_valid_reg[i])
            begin
                fe_found = 1'b1;
                fe_idx   = FAW'(i);
            end
        end
        be_found = 1'b0;
        be_idx   = '0;
        for (int j = BUSY_ENTRIES - 1; j >= 0; j--)
        begin
            if (!busy_valid_reg[j])
            begin
                be_found = 1'b1;
                be_idx   = BAW'(j);
            end
        end
    end

    // Commit decision for both kinds of item.
    always_comb
    begin
        below_hunk = (n_reg < {1'b0, hunk_reg});
        grow      = below_hunk ? {1'b0, hunk_reg} : n_reg;
        limit_eff = (CAP < {2'b00, limit_reg}) ? CAP : {2'b00, limit_reg};
        sum       = {1'b0, used_reg} + {1'b0, grow};
        tot       = lo_len_reg + blen_reg + (hi_reg ? hi_len_reg : 32'd0);
        st        = ST_OK;
        out_addr  = 32'd0;
        out_bytes = 32'd0;
        fr_we     = 1'b0;
        fr_waddr  = '0;
        fr_wdata  = '0;
        br_we     = 1'b0;
        br_waddr  = be_idx;
        br_wdata  = '0;
        hr_we     = 1'b0;
        fv_set    = 1'b0;
        fv_set_idx = fe_idx;
        fv_clr    = 1'b0;
        fv_clr_idx = '0;
        bv_set    = 1'b0;
        bv_clr    = 1'b0;
        grow_ok   = 1'b0;
        if (kind_reg == KIND_ALLOC)
        begin
            if (fit_reg)
            begin
                if (!be_found)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    out_addr = fit_start_reg;
                    if ({1'b0, fit_len_reg} > n_reg)
                    begin
                        fr_we    = 1'b1;
                        fr_waddr = fit_idx_reg;
                        fr_wdata = {fit_start_reg + n_reg[31:0], fit_len_reg - n_reg[31:0]};
                    end
                    else
                    begin
                        fv_clr     = 1'b1;
                        fv_clr_idx = fit_idx_reg;
                    end
                end
            end
            else if (sum > limit_eff)
            begin
                st = ST_LIMIT;
            end
            else if ((hunk_count_reg >= HCW'(HUNK_ENTRIES)) || !be_found
                     || (below_hunk && !fe_found))
            begin
                st = ST_FULL;
            end
            else
            begin
                grow_ok  = 1'b1;
                hr_we    = 1'b1;
                out_addr = used_reg[31:0];
                if (below_hunk)
                begin
                    fr_we    = 1'b1;
                    fr_waddr = fe_idx;
                    fr_wdata = {used_reg[31:0] + n_reg[31:0], hunk_reg - n_reg[31:0]};
                    fv_set   = 1'b1;
                end
            end
            if (st == ST_OK)
            begin
                out_bytes = n_reg[31:0];
                br_we     = 1'b1;
                br_wdata  = {out_addr, n_reg[31:0]};
                bv_set    = 1'b1;
            end
        end
        else
        begin
            if (!bhit_reg)
            begin
                st = ST_NOT_BUSY;
            end
            else if (lo_reg)
            begin
                fr_we    = 1'b1;
                fr_waddr = lo_idx_reg;
                fr_wdata = {lo_start_reg, tot};
                if (hi_reg)
                begin
                    fv_clr     = 1'b1;
                    fv_clr_idx = hi_idx_reg;
                end
            end
            else if (hi_reg)
            begin
                fr_we    = 1'b1;
                fr_waddr = hi_idx_reg;
                fr_wdata = {addr_reg, hi_len_reg + blen_reg};
            end
            else if (fe_found)
            begin
                fr_we    = 1'b1;
                fr_waddr = fe_idx;
                fr_wdata = {addr_reg, blen_reg};
                fv_set   = 1'b1;
            end
            else
            begin
                st = ST_FULL;
            end
            if (st == ST_OK)
            begin
                out_bytes = blen_reg;
                bv_clr    = 1'b1;
            end
        end
        if (!cmd.commit)
        begin
            fr_we  = 1'b0;
            br_we  = 1'b0;
            hr_we  = 1'b0;
            fv_set = 1'b0;
            fv_clr = 1'b0;
            bv_set = 1'b0;
            bv_clr = 1'b0;
            grow_ok = 1'b0;
        end
    end

    // Configuration, item capture and alignment results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunk_raw_reg <= DEFAULT_HUNK;
            limit_reg    <= DEFAULT_LIMIT;
            kind_reg     <= KIND_ALLOC;
            req_reg      <= '0;
            addr_reg     <= '0;
            hunk_reg     <= '0;
            n_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HUNK_SIZE:  hunk_raw_reg <= cfg_data;
                    CFG_HEAP_LIMIT: limit_reg    <= cfg_data;
                    default:        limit_reg    <= limit_reg;
                endcase
            end
            if (cmd.load)
            begin
                kind_reg <= item.kind;
                req_reg  <= item.request_bytes;
                addr_reg <= item.block_address;
            end
            if (cmd.take_hunk)
            begin
                hunk_reg <= (al_result > 33'h0_FFFF_FFFF) ? HCAP : al_result[31:0];
            end
            if (cmd.take_n)
            begin
                n_reg <= al_result;
            end
        end
    end

    // Scan engine: one RAM read issued per cycle, evaluated the next.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg    <= SCAN_FREE;
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            pidx_reg   <= '0;
        end
        else
        begin
            pend_reg <= issue;
            pidx_reg <= cnt_reg;
            if (cmd.scan_go)
            begin
                sel_reg    <= cmd.scan_sel;
                active_reg <= 1'b1;
                cnt_reg    <= '0;
                pend_reg   <= 1'b0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (scan_done)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    // Scan findings, cleared when an item is loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_reg       <= 1'b0;
            fit_idx_reg   <= '0;
            fit_start_reg <= '0;
            fit_len_reg   <= '0;
            bhit_reg      <= 1'b0;
            bidx_reg      <= '0;
            blen_reg      <= '0;
            base_a_reg    <= 1'b0;
            base_e_reg    <= 1'b0;
            lo_reg        <= 1'b0;
            lo_idx_reg    <= '0;
            lo_start_reg  <= '0;
            lo_len_reg    <= '0;
            hi_reg        <= 1'b0;
            hi_idx_reg    <= '0;
            hi_len_reg    <= '0;
        end
        else if (cmd.load)
        begin
            fit_reg    <= 1'b0;
            bhit_reg   <= 1'b0;
            base_a_reg <= 1'b0;
            base_e_reg <= 1'b0;
            lo_reg     <= 1'b0;
            hi_reg     <= 1'b0;
        end
        else
        begin
            if (fit_hit)
            begin
                fit_reg       <= 1'b1;
                fit_idx_reg   <= pidx_f;
                fit_start_reg <= rd_start;
                fit_len_reg   <= rd_len;
            end
            if (b_hit)
            begin
                bhit_reg <= 1'b1;
                bidx_reg <= pidx_reg[BAW-1:0];
                blen_reg <= rd_len;
            end
            if (pend_reg && (sel_reg == SCAN_HUNK))
            begin
                if (hr_rdata == addr_reg)
                begin
                    base_a_reg <= 1'b1;
                end
                if ({1'b0, hr_rdata} == end_addr)
                begin
                    base_e_reg <= 1'b1;
                end
            end
            if (lo_hit)
            begin
                lo_reg       <= 1'b1;
                lo_idx_reg   <= pidx_f;
                lo_start_reg <= rd_start;
                lo_len_reg   <= rd_len;
            end
            if (hi_hit)
            begin
                hi_reg     <= 1'b1;
                hi_idx_reg <= pidx_f;
                hi_len_reg <= rd_len;
            end
        end
    end

    // Valid bits, hunk count, bump pointer and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_valid_reg <= '0;
            busy_valid_reg <= '0;
            hunk_count_reg <= '0;
            used_reg       <= '0;
            result_reg     <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (fv_clr)
            begin
                free_valid_reg[fv_clr_idx] <= 1'b0;
            end
            if (fv_set)
            begin
                free_valid_reg[fv_set_idx] <= 1'b1;
            end
            if (bv_set)
            begin
                busy_valid_reg[be_idx] <= 1'b1;
            end
            if (bv_clr)
            begin
                busy_valid_reg[bidx_reg] <= 1'b0;
            end
            if (grow_ok)
            begin
                hunk_count_reg <= hunk_count_reg + 1'b1;
                used_reg       <= sum[32:0];
            end
            done_reg <= cmd.commit;
            if (cmd.commit)
            begin
                result_reg.granted_address <= out_addr;
                result_reg.granted_bytes   <= out_bytes;
                result_reg.status          <= st;
            end
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

### rtl/core/first_fit_heap_allocator_top.sv
// First-fit heap allocator with coalescing: an item is taken when start is high
// and busy is low. An allocate runs two round-ups (hunk size, then request), a
// free-table scan at one entry a cycle, and a commit. A free scans the busy table,
// then the hunk table and the free table, each walked through its single read
// port, and commits; when the address is not busy it commits after the busy scan.
// The result shows on result for one cycle with done high, the first cycle in
// which busy is low again; the receiver cannot stall it. No clearing pass after
// reset. Depends on ffha_pkg, ffha_ctrl and ffha_datapath.
module first_fit_heap_allocator_top import ffha_pkg::*; #(
    parameter int FREE_ENTRIES = DEF_FREE_ENTRIES,
    parameter int BUSY_ENTRIES = DEF_BUSY_ENTRIES,
    parameter int HUNK_ENTRIES = DEF_HUNK_ENTRIES,
    parameter int ALIGN_BYTES  = DEF_ALIGN_BYTES,
    parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_in_t    item,
    output item_out_t   result,
    output logic        done,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    ffha_cmd_t cmd;
    ffha_sts_t sts;

    // Sequencer.
    ffha_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (item.kind),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Tables, scan logic and result register.
    ffha_datapath #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .BUSY_ENTRIES (BUSY_ENTRIES),
        .HUNK_ENTRIES (HUNK_ENTRIES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result),
        .done      (done)
    );

endmodule

### rtl/core/ffha_checker.sv
// Port-level checker of the allocator and its bind to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator_top_assert.svh.
`include "first_fit_heap_allocator_top_assert.svh"

module ffha_port_checker import ffha_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input item_in_t  item,
    input item_out_t result,
    input logic      done
);

    // An accepted item makes the block busy in the next cycle.
    `FFHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy did not rise after accept")

    // Each item gives a single-cycle result strobe.
    `FFHA_ASSERT_NEXT(a_done_single, done, !done, "done held for two cycles")

    // A failed item reports no address and no size.
    `FFHA_ASSERT_SAME(a_err_zero, done && (result.status != ST_OK),
        (result.granted_address == 32'd0) && (result.granted_bytes == 32'd0),
        "error result carries a nonzero field")

    // A successful item always moves a nonzero size.
    `FFHA_ASSERT_SAME(a_ok_bytes, done && (result.status == ST_OK),
        result.granted_bytes != 32'd0, "ok result with zero size")

endmodule

bind first_fit_heap_allocator_top ffha_port_checker u_ffha_checker (.*);
